// File: design/pdf_pkg.sv
package pdf_pkg;

  localparam int unsigned POS_W    = 17;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [7:0]  MAGIC_0  = 8'h52;  // 'R'
  localparam logic [7:0]  MAGIC_1  = 8'h42;  // 'B'
  localparam int unsigned CRC_COVER_END = 24;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_HDR   = 2'd2;
  localparam logic [1:0] STATUS_CRC   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_VERSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TYPE_MAX = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_datagram;
  } in_t;

  typedef struct packed {
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic        done_res;
    logic [1:0]  status;
    logic [7:0]  packet_type;
    logic [7:0]  profile;
    logic [7:0]  generation;
    logic [31:0] sequence_res;
    logic [31:0] frame_number;
    logic [31:0] timestamp_ms;
    logic [15:0] header_flags;
  } out_t;

  typedef struct packed {
    logic [7:0] protocol_version;
    logic [7:0] type_min;
    logic [7:0] type_max;
  } cfg_t;

endpackage

// File: design/pdf_crc8.sv
module pdf_crc8 (
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  // reflected crc-32, one byte folded in bit by bit
  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ pdf_pkg::CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

// File: design/pdf_core.sv
module pdf_core #(
  parameter int unsigned HDR_BYTES = 28
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pdf_pkg::cfg_t  cfg,
  input  pdf_pkg::in_t   item,
  input  logic           step,
  output logic           gives_result,
  output pdf_pkg::out_t  res
);

  localparam int unsigned TOT_W = pdf_pkg::POS_W + 1;
  localparam logic [pdf_pkg::POS_W-1:0] HDR_POS = pdf_pkg::POS_W'(HDR_BYTES);
  localparam logic [pdf_pkg::POS_W-1:0] POS_MAX = {pdf_pkg::POS_W{1'b1}};
  localparam logic [pdf_pkg::POS_W-1:0] COVER_END = pdf_pkg::POS_W'(pdf_pkg::CRC_COVER_END);

  logic [pdf_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0] crc_r, crc_nxt, crc_upd;
  logic        prefix_ok_r, prefix_ok_nxt;
  logic [15:0] hlen_r, hlen_nxt;
  logic [15:0] plen_r, plen_nxt;
  logic [31:0] rcrc_r, rcrc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  profile_r, profile_nxt;
  logic [7:0]  gen_r, gen_nxt;
  logic [31:0] seq_r, seq_nxt;
  logic [31:0] frame_r, frame_nxt;
  logic [31:0] tstamp_r, tstamp_nxt;
  logic [15:0] flags_r, flags_nxt;

  logic              is_payload;
  logic              last;
  logic [7:0]        b;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  len_sum;
  logic [1:0]        status;

  assign b          = item.data_byte;
  assign last       = item.end_of_datagram;
  assign is_payload = (pos_r >= HDR_POS);
  assign gives_result = is_payload || last;

  pdf_crc8 u_crc (
    .crc_in  (crc_r),
    .data    (b),
    .crc_out (crc_upd)
  );

  // spare header bytes and the stored crc word stay out of the crc
  assign crc_nxt = (pos_r < COVER_END || is_payload) ? crc_upd : crc_r;

  always_comb begin
    prefix_ok_nxt = prefix_ok_r;
    type_nxt      = type_r;
    profile_nxt   = profile_r;
    gen_nxt       = gen_r;
    hlen_nxt      = hlen_r;
    seq_nxt       = seq_r;
    frame_nxt     = frame_r;
    tstamp_nxt    = tstamp_r;
    plen_nxt      = plen_r;
    flags_nxt     = flags_r;
    rcrc_nxt      = rcrc_r;
    if (!is_payload) begin
      priority if (pos_r == 17'd0) begin
        if (b != pdf_pkg::MAGIC_0) prefix_ok_nxt = 1'b0;
      end else if (pos_r == 17'd1) begin
        if (b != pdf_pkg::MAGIC_1) prefix_ok_nxt = 1'b0;
      end else if (pos_r == 17'd2) begin
        if (b != cfg.protocol_version) prefix_ok_nxt = 1'b0;
      end else if (pos_r == 17'd3) begin
        type_nxt = b;
      end else if (pos_r == 17'd4) begin
        profile_nxt = b;
      end else if (pos_r == 17'd5) begin
        gen_nxt = b;
      end else if (pos_r <= 17'd7) begin
        hlen_nxt = {hlen_r[7:0], b};
      end else if (pos_r <= 17'd11) begin
        seq_nxt = {seq_r[23:0], b};
      end else if (pos_r <= 17'd15) begin
        frame_nxt = {frame_r[23:0], b};
      end else if (pos_r <= 17'd19) begin
        tstamp_nxt = {tstamp_r[23:0], b};
      end else if (pos_r <= 17'd21) begin
        plen_nxt = {plen_r[7:0], b};
      end else if (pos_r <= 17'd23) begin
        flags_nxt = {flags_r[7:0], b};
      end else if (pos_r <= 17'd27) begin
        rcrc_nxt = {rcrc_r[23:0], b};
      end else begin
        rcrc_nxt = rcrc_r;
      end
    end
  end

  assign total   = {1'b0, pos_r} + TOT_W'(1);
  assign len_sum = TOT_W'(hlen_nxt) + TOT_W'(plen_nxt);

  // order of checks: short, header or length, crc
  always_comb begin
    priority if (total < TOT_W'(HDR_BYTES)) begin
      status = pdf_pkg::STATUS_SHORT;
    end else if (!prefix_ok_nxt || type_nxt < cfg.type_min || type_nxt > cfg.type_max ||
                 hlen_nxt != 16'(HDR_BYTES) || total != len_sum) begin
      status = pdf_pkg::STATUS_HDR;
    end else if (rcrc_nxt != ~crc_nxt) begin
      status = pdf_pkg::STATUS_CRC;
    end else begin
      status = pdf_pkg::STATUS_OK;
    end
  end

  always_comb begin
    res = '0;
    res.payload_valid = is_payload;
    res.payload_byte  = is_payload ? b : 8'd0;
    if (last) begin
      res.done_res     = 1'b1;
      res.status       = status;
      res.packet_type  = type_nxt;
      res.profile      = profile_nxt;
      res.generation   = gen_nxt;
      res.sequence_res = seq_nxt;
      res.frame_number = frame_nxt;
      res.timestamp_ms = tstamp_nxt;
      res.header_flags = flags_nxt;
    end
  end

  assign pos_nxt = (pos_r < POS_MAX) ? pos_r + 17'd1 : pos_r;

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last)) begin
      pos_r       <= '0;
      crc_r       <= pdf_pkg::CRC_INIT;
      prefix_ok_r <= 1'b1;
      hlen_r      <= '0;
      plen_r      <= '0;
      rcrc_r      <= '0;
      type_r      <= '0;
      profile_r   <= '0;
      gen_r       <= '0;
      seq_r       <= '0;
      frame_r     <= '0;
      tstamp_r    <= '0;
      flags_r     <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      crc_r       <= crc_nxt;
      prefix_ok_r <= prefix_ok_nxt;
      hlen_r      <= hlen_nxt;
      plen_r      <= plen_nxt;
      rcrc_r      <= rcrc_nxt;
      type_r      <= type_nxt;
      profile_r   <= profile_nxt;
      gen_r       <= gen_nxt;
      seq_r       <= seq_nxt;
      frame_r     <= frame_nxt;
      tstamp_r    <= tstamp_nxt;
      flags_r     <= flags_nxt;
    end
  end

endmodule

// File: design/packet_deframer_crc32.sv
// channel  | direction | handshake           | payload
// in_      | input     | in_valid / in_stall | pdf_pkg::in_t  (data_byte, end_of_datagram)
// out_     | output    | out_valid/out_stall | pdf_pkg::out_t (payload byte, status, header)
// cfg_     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data (ready always high)
//
// one byte per cycle sustained while the result is not stalled; an accepted byte reaches the result
// register through the input register, then one pass of crc byte update and header capture
// header bytes that are not final make no result and never wait on out_stall
// synchronous reset clears datagram state, handshake valids and config to defaults
// a stalled result holds; a byte waiting behind it stalls the input
module packet_deframer_crc32 #(
  parameter int unsigned HDR_BYTES = 28
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  pdf_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output pdf_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [7:0]                         cfg_data
);

  pdf_pkg::cfg_t cfg_r;
  pdf_pkg::in_t  in_data_r;
  logic          in_valid_r;
  pdf_pkg::out_t out_data_r;
  logic          out_valid_r;

  logic          gives_result;
  logic          out_free;
  logic          proc;
  logic          in_take;
  pdf_pkg::out_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.protocol_version <= 8'd1;
      cfg_r.type_min         <= 8'd1;
      cfg_r.type_max         <= 8'd4;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pdf_pkg::CFG_VERSION:  cfg_r.protocol_version <= cfg_data;
        pdf_pkg::CFG_TYPE_MIN: cfg_r.type_min         <= cfg_data;
        pdf_pkg::CFG_TYPE_MAX: cfg_r.type_max         <= cfg_data;
        default:               cfg_r                  <= cfg_r;
      endcase
    end
  end

  pdf_core #(
    .HDR_BYTES (HDR_BYTES)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .item         (in_data_r),
    .step         (proc),
    .gives_result (gives_result),
    .res          (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  // the held byte moves on unless it makes a result and the result slot is full
  assign proc     = in_valid_r && (!gives_result || out_free);
  assign in_stall = in_valid_r && !proc;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || proc) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc && gives_result) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc && gives_result) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // every result carries a payload byte or closes a datagram
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.payload_valid || out_data_r.done_res))
    else $error("result with neither payload nor done");

  // status and header fields stay zero on mid-datagram items
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.done_res) |->
      (out_data_r.status == pdf_pkg::STATUS_OK && out_data_r.sequence_res == 32'd0))
    else $error("header fields on a payload-only item");

  // a new result always comes from the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_valid_r))
    else $error("result without a held byte");
`endif

endmodule

// File: tb/sv/deframer_checker.sv
`timescale 1ns / 100ps

module deframer_checker #(
  parameter int unsigned HDR_BYTES = 28
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  pdf_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  pdf_pkg::out_t                 out_data,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                    cfg_data,
  output int                            pending,
  output int                            fail_count
);

  localparam int unsigned POS_LIMIT = (1 << pdf_pkg::POS_W) - 1;
  localparam logic [7:0] RESET_VERSION  = 8'd1;
  localparam logic [7:0] RESET_TYPE_MIN = 8'd1;
  localparam logic [7:0] RESET_TYPE_MAX = 8'd4;
  localparam int MAX_PRINTED = 50;

  pdf_pkg::cfg_t             cfg_shadow;
  logic [pdf_pkg::POS_W-1:0] byte_pos;
  logic [31:0]      crc_acc;
  logic             prefix_ok;
  logic [15:0]      hdr_len_q;
  logic [15:0]      pay_len_q;
  logic [31:0]      crc_rx_q;
  logic [7:0]       type_q;
  logic [7:0]       profile_q;
  logic [7:0]       gen_q;
  logic [31:0]      seq_q;
  logic [31:0]      frame_q;
  logic [31:0]      stamp_q;
  logic [15:0]      flags_q;

  pdf_pkg::out_t expected_results[$];
  int   errors = 0;

  assign fail_count = errors;

  function automatic logic [31:0] crc_step(logic [31:0] crc, logic [7:0] b);
    crc ^= {24'd0, b};
    repeat (8) crc = crc[0] ? ((crc >> 1) ^ pdf_pkg::CRC_POLY) : (crc >> 1);
    return crc;
  endfunction

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t: mismatch: %s", $time, msg);
    end
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic clear_datagram();
    byte_pos  = '0;
    crc_acc   = pdf_pkg::CRC_INIT;
    prefix_ok = 1'b1;
    hdr_len_q = '0;
    pay_len_q = '0;
    crc_rx_q  = '0;
    type_q    = '0;
    profile_q = '0;
    gen_q     = '0;
    seq_q     = '0;
    frame_q   = '0;
    stamp_q   = '0;
    flags_q   = '0;
  endtask

  // one datagram byte in, at most one result out
  task automatic predict_byte(logic [7:0] b, logic last);
    logic          is_pay;
    int unsigned   total;
    pdf_pkg::out_t r;
    is_pay = (byte_pos >= HDR_BYTES);
    r = '0;
    if (byte_pos < pdf_pkg::CRC_COVER_END || is_pay) crc_acc = crc_step(crc_acc, b);
    // header capture; matching magic and version bytes fall through into the length shift
    if (!is_pay) begin
      if (byte_pos == 0 && b != pdf_pkg::MAGIC_0) prefix_ok = 1'b0;
      else if (byte_pos == 1 && b != pdf_pkg::MAGIC_1) prefix_ok = 1'b0;
      else if (byte_pos == 2 && b != cfg_shadow.protocol_version) prefix_ok = 1'b0;
      else if (byte_pos == 3) type_q = b;
      else if (byte_pos == 4) profile_q = b;
      else if (byte_pos == 5) gen_q = b;
      else if (byte_pos <= 7) hdr_len_q = {hdr_len_q[7:0], b};
      else if (byte_pos <= 11) seq_q = {seq_q[23:0], b};
      else if (byte_pos <= 15) frame_q = {frame_q[23:0], b};
      else if (byte_pos <= 19) stamp_q = {stamp_q[23:0], b};
      else if (byte_pos <= 21) pay_len_q = {pay_len_q[7:0], b};
      else if (byte_pos <= 23) flags_q = {flags_q[7:0], b};
      else if (byte_pos <= 27) crc_rx_q = {crc_rx_q[23:0], b};
    end
    if (!last) begin
      if (byte_pos < POS_LIMIT) byte_pos = byte_pos + 1'b1;
      if (is_pay) begin
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        expected_results.insert(expected_results.size(), r);
      end
    end else begin
      total = 32'(byte_pos) + 1;
      if (total < HDR_BYTES) begin
        r.status = pdf_pkg::STATUS_SHORT;
      end else if (!prefix_ok || type_q < cfg_shadow.type_min ||
                   type_q > cfg_shadow.type_max || 32'(hdr_len_q) != HDR_BYTES ||
                   total != 32'(hdr_len_q) + 32'(pay_len_q)) begin
        r.status = pdf_pkg::STATUS_HDR;
      end else if (crc_rx_q != ~crc_acc) begin
        r.status = pdf_pkg::STATUS_CRC;
      end else begin
        r.status = pdf_pkg::STATUS_OK;
      end
      r.payload_valid = is_pay;
      r.payload_byte  = is_pay ? b : 8'd0;
      r.done_res      = 1'b1;
      r.packet_type   = type_q;
      r.profile       = profile_q;
      r.generation    = gen_q;
      r.sequence_res  = seq_q;
      r.frame_number  = frame_q;
      r.timestamp_ms  = stamp_q;
      r.header_flags  = flags_q;
      expected_results.insert(expected_results.size(), r);
      clear_datagram();
    end
  endtask

  always @(posedge clk) begin
    pdf_pkg::out_t want;
    if (!rst_n) begin
      cfg_shadow.protocol_version = RESET_VERSION;
      cfg_shadow.type_min         = RESET_TYPE_MIN;
      cfg_shadow.type_max         = RESET_TYPE_MAX;
      clear_datagram();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          pdf_pkg::CFG_VERSION:  cfg_shadow.protocol_version = cfg_data;
          pdf_pkg::CFG_TYPE_MIN: cfg_shadow.type_min = cfg_data;
          pdf_pkg::CFG_TYPE_MAX: cfg_shadow.type_max = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_byte(in_data.data_byte, in_data.end_of_datagram);
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected: %h", out_data));
        end else begin
          want = expected_results.pop_front();
          check_field("payload_valid", 32'(out_data.payload_valid), 32'(want.payload_valid));
          check_field("payload_byte", 32'(out_data.payload_byte), 32'(want.payload_byte));
          check_field("done_res", 32'(out_data.done_res), 32'(want.done_res));
          check_field("status", 32'(out_data.status), 32'(want.status));
          check_field("packet_type", 32'(out_data.packet_type), 32'(want.packet_type));
          check_field("profile", 32'(out_data.profile), 32'(want.profile));
          check_field("generation", 32'(out_data.generation), 32'(want.generation));
          check_field("sequence_res", out_data.sequence_res, want.sequence_res);
          check_field("frame_number", out_data.frame_number, want.frame_number);
          check_field("timestamp_ms", out_data.timestamp_ms, want.timestamp_ms);
          check_field("header_flags", 32'(out_data.header_flags), 32'(want.header_flags));
        end
      end
    end
    pending <= expected_results.size();
  end

endmodule

// File: tb/sv/packet_deframer_crc32_tb.sv
`timescale 1ns / 100ps

module packet_deframer_crc32_tb;

  localparam int unsigned HDR_BYTES = 28;
  localparam int unsigned FIXED_HDR = 28;
  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 6;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_BYTES  = 170;

  typedef enum {
    DG_GOOD, DG_SHORT, DG_BAD_MAGIC, DG_BAD_VERSION, DG_BAD_TYPE,
    DG_BAD_HLEN, DG_BAD_LENGTH, DG_BAD_CRC, DG_NOISE
  } dgram_kind_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  pdf_pkg::in_t                  in_data = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  pdf_pkg::out_t                 out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [pdf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]                    cfg_data = '0;

  int pending_results;
  int failures;

  int idle_pct = 0;
  int stall_pct = 0;
  logic long_hold_req = 1'b0;
  logic hold_started = 1'b0;
  int hold_left = 0;

  logic [7:0] cur_ver = 8'd1;
  logic [7:0] cur_min = 8'd1;
  logic [7:0] cur_max = 8'd4;
  logic [7:0] dgram[$];

  always #4 clk = ~clk;

  packet_deframer_crc32 #(.HDR_BYTES(HDR_BYTES)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  deframer_checker #(.HDR_BYTES(HDR_BYTES)) result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending_results),
    .fail_count (failures)
  );

  // receiver: random stalls, plus one long hold-off to back up the input
  always @(posedge clk) begin
    if (long_hold_req && !hold_started) begin
      hold_started = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] crc_add(logic [31:0] crc, logic [7:0] b);
    crc ^= {24'd0, b};
    repeat (8) crc = crc[0] ? ((crc >> 1) ^ pdf_pkg::CRC_POLY) : (crc >> 1);
    return crc;
  endfunction

  task automatic build_datagram(dgram_kind_t kind, int unsigned n_pay);
    logic [7:0]  hdr[FIXED_HDR];
    logic [7:0]  pay[$];
    logic [31:0] crc;
    logic [7:0]  ty;
    int unsigned cut;
    dgram.delete();
    if (kind == DG_NOISE) begin
      repeat ($urandom_range(40, 1)) dgram.insert(dgram.size(), 8'($urandom));
    end else begin
      ty = (cur_min <= cur_max) ? 8'($urandom_range(cur_max, cur_min)) : 8'($urandom);
      if (kind == DG_BAD_TYPE) begin
        if (cur_min > 0) ty = 8'($urandom_range(cur_min - 1, 0));
        else if (cur_max < 255) ty = 8'($urandom_range(255, cur_max + 1));
      end
      foreach (hdr[i]) hdr[i] = 8'($urandom);
      hdr[0] = pdf_pkg::MAGIC_0;
      hdr[1] = pdf_pkg::MAGIC_1;
      hdr[2] = cur_ver;
      hdr[3] = ty;
      {hdr[6], hdr[7]} = 16'(HDR_BYTES);
      {hdr[20], hdr[21]} = 16'(n_pay);
      case (kind)
        DG_BAD_MAGIC: begin
          if ($urandom_range(1)) hdr[0] ^= 8'($urandom_range(255, 1));
          else hdr[1] ^= 8'($urandom_range(255, 1));
        end
        DG_BAD_VERSION: hdr[2] ^= 8'($urandom_range(255, 1));
        DG_BAD_HLEN: {hdr[6], hdr[7]} ^= 16'($urandom_range(65535, 1));
        DG_BAD_LENGTH: begin
          if ($urandom_range(1) && n_pay > 0) {hdr[20], hdr[21]} = 16'(n_pay - 1);
          else {hdr[20], hdr[21]} = 16'(n_pay + $urandom_range(5, 1));
        end
        default: ;
      endcase
      repeat (n_pay) pay.insert(pay.size(), 8'($urandom));
      crc = pdf_pkg::CRC_INIT;
      for (int i = 0; i < pdf_pkg::CRC_COVER_END; i++) crc = crc_add(crc, hdr[i]);
      foreach (pay[i]) crc = crc_add(crc, pay[i]);
      {hdr[24], hdr[25], hdr[26], hdr[27]} = ~crc;
      if (kind == DG_BAD_CRC) begin
        if (n_pay > 0 && $urandom_range(1)) begin
          pay[$urandom_range(n_pay - 1)] ^= 8'(1 << $urandom_range(7));
        end else begin
          hdr[24 + $urandom_range(3)] ^= 8'(1 << $urandom_range(7));
        end
      end
      foreach (hdr[i]) dgram.insert(dgram.size(), hdr[i]);
      // spare header bytes, if the header is configured wider
      for (int i = FIXED_HDR; i < HDR_BYTES; i++) dgram.insert(dgram.size(), 8'($urandom));
      foreach (pay[i]) dgram.insert(dgram.size(), pay[i]);
      if (kind == DG_SHORT) begin
        cut = $urandom_range(HDR_BYTES - 1, 1);
        while (dgram.size() > cut) void'(dgram.pop_back());
      end
    end
  endtask

  task automatic send_item(logic [7:0] b, logic last);
    pdf_pkg::in_t item;
    item.data_byte = b;
    item.end_of_datagram = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_datagram();
    foreach (dgram[i]) send_item(dgram[i], i == dgram.size() - 1);
  endtask

  // wait until every predicted result has come back or DRAIN_LIMIT runs out, then let the pipeline settle
  task automatic drain();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [7:0] ver, logic [7:0] lo, logic [7:0] hi);
    logic [pdf_pkg::CFG_IDX_W-1:0] idx[3];
    logic [7:0]                    val[3];
    idx = '{pdf_pkg::CFG_VERSION, pdf_pkg::CFG_TYPE_MIN, pdf_pkg::CFG_TYPE_MAX};
    val = '{ver, lo, hi};
    for (int i = 0; i < 3; i++) begin
      cfg_index <= idx[i];
      cfg_data <= val[i];
      if (i == 0) cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cur_ver = ver;
    cur_min = lo;
    cur_max = hi;
  endtask

  task automatic run_phase(logic [7:0] ver, logic [7:0] lo, logic [7:0] hi,
                           int sender_idle, int receiver_stall, int n_bytes);
    int          sent;
    int          r;
    int unsigned n_pay;
    dgram_kind_t kind;
    sent = 0;
    drain();
    write_config(ver, lo, hi);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    while (sent < n_bytes) begin
      r = $urandom_range(99);
      kind = r < 55 ? DG_GOOD : r < 62 ? DG_SHORT : r < 67 ? DG_BAD_MAGIC :
             r < 72 ? DG_BAD_VERSION : r < 77 ? DG_BAD_TYPE : r < 82 ? DG_BAD_HLEN :
             r < 87 ? DG_BAD_LENGTH : r < 94 ? DG_BAD_CRC : DG_NOISE;
      n_pay = ($urandom_range(9) == 0) ? $urandom_range(64, 16) : $urandom_range(8, 0);
      build_datagram(kind, n_pay);
      sent += dgram.size();
      send_datagram();
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone final byte, then a header-only packet at reset settings
    dgram.delete();
    dgram.insert(0, 8'hFF);
    send_datagram();
    build_datagram(DG_GOOD, 0);
    send_datagram();

    run_phase(8'd1, 8'd1, 8'd4, 0, 0, PHASE_BYTES);
    long_hold_req <= 1'b1;
    repeat (4) begin
      build_datagram(DG_GOOD, 40);
      send_datagram();
    end

    run_phase(8'd0, 8'd0, 8'd255, 85, 0, PHASE_BYTES);
    run_phase(8'd255, 8'd255, 8'd255, 0, 85, PHASE_BYTES);
    // empty type range
    run_phase(8'd200, 8'd200, 8'd100, 31, 31, PHASE_BYTES);
    run_phase(8'($urandom), 8'($urandom_range(8)), 8'($urandom_range(255, 8)), 0, 0,
              PHASE_BYTES / 2);

    drain();
    if (pending_results != 0) begin
      $display("%0d expected results never arrived", pending_results);
    end
    if (failures == 0 && pending_results == 0) begin
      $display("** packet_deframer_crc32: PASSED **");
    end else begin
      $display("** packet_deframer_crc32: FAILED **");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("timeout");
    $display("** packet_deframer_crc32: FAILED **");
    $finish;
  end

endmodule

// File: files.f
design/pdf_pkg.sv
design/pdf_crc8.sv
design/pdf_core.sv
design/packet_deframer_crc32.sv
tb/sv/deframer_checker.sv
tb/sv/packet_deframer_crc32_tb.sv
